>>> rtl/attitude_pid_step_macros.svh
// Assertion macros for the attitude PID top level.
`ifndef ATTITUDE_PID_STEP_MACROS_SVH
`define ATTITUDE_PID_STEP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APID_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define APID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/apid_pkg.sv
// Types and constants for the attitude PID datapath.
package apid_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAX_INCLINATION = 3'd0,
      REG_PROP_GAIN       = 3'd1,
      REG_RATE_GAIN       = 3'd2,
      REG_INTEG_GAIN      = 3'd3,
      REG_INTEG_MIN       = 3'd4,
      REG_INTEG_MAX       = 3'd5,
      REG_DERIV_GAIN      = 3'd6
   } reg_index_type;

   // Divide-by-constant via reciprocal multiply: M = ceil(2^S / D), exact for 31-bit values.
   localparam longint P_DIV   = 100;
   localparam int     P_SHIFT = 38;
   localparam logic [31:0] P_RECIP =
      32'(((64'd1 << P_SHIFT) + 64'(P_DIV) - 64'd1) / 64'(P_DIV));

   localparam longint R_DIV   = 80 * 19;
   localparam int     R_SHIFT = 42;
   localparam logic [31:0] R_RECIP =
      32'(((64'd1 << R_SHIFT) + 64'(R_DIV) - 64'd1) / 64'(R_DIV));

   localparam int I_SHIFT = 12;   // integral scale 1/4096
   localparam int D_SHIFT = 11;   // derivative scale 1/2048

   localparam int P_Q_W = 25;     // |kp*err|/100 < 2^25
   localparam int R_Q_W = 21;     // |kr*spd|/1520 < 2^21

   typedef struct packed {
      logic        [14:0] max_inclination;
      logic        [15:0] prop_gain;
      logic        [15:0] rate_gain;
      logic        [15:0] integ_gain;
      logic signed [31:0] integ_min;
      logic signed [31:0] integ_max;
      logic        [15:0] deriv_gain;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] err;
      logic signed [15:0] spd;
      logic signed [31:0] integ;
      logic signed [18:0] dsum;
   } front_type;

   typedef struct packed {
      logic        [30:0] p_mag;
      logic               p_neg;
      logic        [30:0] r_mag;
      logic               r_neg;
      logic signed [47:0] i_prod;
      logic signed [34:0] d_prod;
   } prod_type;

   typedef struct packed {
      logic signed [P_Q_W:0] p_term;
      logic signed [R_Q_W:0] r_term;
      logic signed [35:0]    i_term;
      logic signed [23:0]    d_term;
   } term_type;

endpackage

>>> rtl/apid_csr.sv
// Configuration register file for the attitude PID.
module apid_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [apid_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [apid_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output apid_pkg::cfg_type                  cfg
);
   import apid_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (reg_index_type'(csr_index))
            REG_MAX_INCLINATION: cfg_in.max_inclination = csr_wdata[14:0];
            REG_PROP_GAIN:       cfg_in.prop_gain       = csr_wdata[15:0];
            REG_RATE_GAIN:       cfg_in.rate_gain       = csr_wdata[15:0];
            REG_INTEG_GAIN:      cfg_in.integ_gain      = csr_wdata[15:0];
            REG_INTEG_MIN:       cfg_in.integ_min       = $signed(csr_wdata[31:0]);
            REG_INTEG_MAX:       cfg_in.integ_max       = $signed(csr_wdata[31:0]);
            REG_DERIV_GAIN:      cfg_in.deriv_gain      = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/apid_front.sv
// Error clamp, integrator and speed-delta history; holds the loop state.
module apid_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic signed [15:0]  set_point,
   input  logic signed [11:0]  body_angle,
   input  logic signed [15:0]  angle_speed,
   input  apid_pkg::cfg_type   cfg,
   output apid_pkg::front_type front
);
   import apid_pkg::*;

   logic signed [17:0] err_raw;
   logic signed [17:0] lim;
   logic signed [17:0] err_clamp;
   logic signed [32:0] integ_sum;
   logic signed [16:0] delta;

   logic signed [31:0] integ_ff,      integ_in;
   logic signed [15:0] prev_speed_ff;
   logic signed [16:0] delta_new_ff;
   logic signed [16:0] delta_old_ff;
   logic signed [15:0] err_ff;
   logic signed [18:0] dsum_ff,       dsum_in;

   always_comb begin
      err_raw = {set_point[15], set_point, 1'b0} - 18'(body_angle);
      lim     = {3'b000, cfg.max_inclination};
      priority if (err_raw < -lim) begin
         err_clamp = -lim;
      end else if (err_raw > lim) begin
         err_clamp = lim;
      end else begin
         err_clamp = err_raw;
      end
   end

   // Lower limit tested first; inverted: integ_min if below, else max.
   always_comb begin
      integ_sum = 33'(integ_ff) + 33'(err_clamp);
      priority if (integ_sum < 33'(cfg.integ_min)) begin
         integ_in = cfg.integ_min;
      end else if (integ_sum > 33'(cfg.integ_max)) begin
         integ_in = cfg.integ_max;
      end else begin
         integ_in = integ_sum[31:0];
      end
   end

   assign delta   = 17'(angle_speed) - 17'(prev_speed_ff);
   assign dsum_in = 19'(delta) + 19'(delta_new_ff) + 19'(delta_old_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         prev_speed_ff <= '0;
         delta_new_ff  <= '0;
         delta_old_ff  <= '0;
      end else if (en) begin
         integ_ff      <= integ_in;
         prev_speed_ff <= angle_speed;
         delta_new_ff  <= delta;
         delta_old_ff  <= delta_new_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         err_ff  <= err_clamp[15:0];
         dsum_ff <= dsum_in;
      end
   end

   // The updated state doubles as this stage's output register.
   assign front.err   = err_ff;
   assign front.spd   = prev_speed_ff;
   assign front.integ = integ_ff;
   assign front.dsum  = dsum_ff;

endmodule

>>> rtl/apid_mul.sv
// Gain multiplications; P and rate paths kept as sign and magnitude.
module apid_mul (
   input  logic                clock,
   input  logic                en,
   input  apid_pkg::cfg_type   cfg,
   input  apid_pkg::front_type front,
   output apid_pkg::prod_type  prod
);
   import apid_pkg::*;

   logic     [15:0] err_abs;
   logic     [15:0] spd_abs;
   prod_type        prod_ff;
   prod_type        prod_in;

   always_comb begin
      err_abs        = front.err[15] ? 16'(-front.err) : 16'(front.err);
      spd_abs        = front.spd[15] ? 16'(-front.spd) : 16'(front.spd);
      prod_in.p_mag  = 31'(cfg.prop_gain) * 31'(err_abs[14:0]);
      prod_in.p_neg  = front.err[15];
      prod_in.r_mag  = 31'(cfg.rate_gain) * 31'(spd_abs);
      prod_in.r_neg  = front.spd[15];
      prod_in.i_prod = 48'(front.integ) * 48'($signed({1'b0, cfg.integ_gain}));
      prod_in.d_prod = 35'(front.dsum) * 35'($signed({1'b0, cfg.deriv_gain}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> rtl/apid_scale.sv
// Constant-divisor scaling of the four products, truncating toward zero.
module apid_scale (
   input  logic                clock,
   input  logic                en,
   input  apid_pkg::prod_type  prod,
   output apid_pkg::term_type  term
);
   import apid_pkg::*;

   logic        [62:0] p_full;
   logic        [62:0] r_full;
   logic        [P_Q_W-1:0] p_q;
   logic        [R_Q_W-1:0] r_q;
   logic signed [47:0] i_adj;
   logic signed [34:0] d_adj;
   term_type           term_ff;
   term_type           term_in;

   always_comb begin
      p_full = 63'(prod.p_mag) * 63'(P_RECIP);
      r_full = 63'(prod.r_mag) * 63'(R_RECIP);
      p_q    = p_full[P_SHIFT +: P_Q_W];
      r_q    = r_full[R_SHIFT +: R_Q_W];
      // Bias negatives so the arithmetic shift truncates toward zero.
      i_adj  = prod.i_prod + (prod.i_prod[47] ? 48'sd4095 : 48'sd0);
      d_adj  = prod.d_prod + (prod.d_prod[34] ? 35'sd2047 : 35'sd0);

      term_in.p_term = prod.p_neg ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
      term_in.r_term = prod.r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
      term_in.i_term = i_adj[47:I_SHIFT];
      term_in.d_term = d_adj[34:D_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

>>> rtl/attitude_pid_step.sv
// Top level of the one-axis attitude PID step: handshake, pipeline control, output sum.
// Each accepted transaction moves through the stages in order; back-pressure can hold it.
// Throughput: one transaction per cycle while rsp_ready does not stall the pipeline.
// Pipeline: input register, state update, gain multiply, constant scaling, output register.
// Reset (synchronous, active high) clears all configuration registers, the integrator,
// the speed history and every stage valid; no results are pending after reset.
module attitude_pid_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [15:0]               req_set_point,
   input  logic signed [11:0]               req_body_angle,
   input  logic signed [15:0]               req_angle_speed,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_pid_output,
   input  logic                             csr_write_en,
   input  logic [apid_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [apid_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import apid_pkg::*;

   cfg_type   cfg;
   front_type front;
   prod_type  prod;
   term_type  term;

   // Stage valids: input register, front, multiply, scale, output.
   logic v0_ff, v1_ff, v2_ff, v3_ff, out_v_ff;
   logic load0, load1, load2, load3, load_out;
   logic en0, en1, en2, en3, en_out;

   logic signed [15:0] sp_ff;
   logic signed [11:0] ang_ff;
   logic signed [15:0] spd_ff;

   logic signed [37:0] total;
   logic signed [31:0] pid_in;
   logic signed [31:0] pid_ff;

   // A stage may load when empty or when its occupant moves on this edge.
   // Bubbles collapse, so input keeps flowing while a result waits downstream.
   always_comb begin
      load_out = !out_v_ff || rsp_ready;
      load3    = !v3_ff || load_out;
      load2    = !v2_ff || load3;
      load1    = !v1_ff || load2;
      load0    = !v0_ff || load1;
      en0      = req_valid && load0;
      en1      = v0_ff && load1;
      en2      = v1_ff && load2;
      en3      = v2_ff && load3;
      en_out   = v3_ff && load_out;
   end

   // Refuse transactions while reset is held.
   assign req_ready = load0 && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (load0)    v0_ff    <= req_valid;
         if (load1)    v1_ff    <= v0_ff;
         if (load2)    v2_ff    <= v1_ff;
         if (load3)    v3_ff    <= v2_ff;
         if (load_out) out_v_ff <= v3_ff;
      end
   end

   // Capture the accepted transaction.
   always_ff @(posedge clock) begin
      if (en0) begin
         sp_ff  <= req_set_point;
         ang_ff <= req_body_angle;
         spd_ff <= req_angle_speed;
      end
   end

   apid_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // State advances exactly once per transaction, as it leaves the input register.
   apid_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en1),
      .set_point   (sp_ff),
      .body_angle  (ang_ff),
      .angle_speed (spd_ff),
      .cfg         (cfg),
      .front       (front)
   );

   apid_mul u_mul (
      .clock (clock),
      .en    (en2),
      .cfg   (cfg),
      .front (front),
      .prod  (prod)
   );

   apid_scale u_scale (
      .clock (clock),
      .en    (en3),
      .prod  (prod),
      .term  (term)
   );

   // P - R + I - D, with the rate term R subtracted alongside P, then saturate to 32 bits.
   always_comb begin
      total = 38'(term.p_term) - 38'(term.r_term) + 38'(term.i_term) - 38'(term.d_term);
      priority if (total > 38'sh0_7FFF_FFFF) begin
         pid_in = 32'sh7FFF_FFFF;
      end else if (total < -38'sh0_8000_0000) begin
         pid_in = 32'sh8000_0000;
      end else begin
         pid_in = total[31:0];
      end
   end

   // Hold the result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (en_out) begin
         pid_ff <= pid_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_pid_output = pid_ff;

   `include "attitude_pid_step_macros.svh"

   `APID_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_valid && req_ready, v0_ff, "accepted transaction lost at input register")
   `APID_ASSERT_NOW(a_rsp_from_scale, clock, reset, $rose(out_v_ff), $past(v3_ff), "result appeared without a scaled transaction")
   `APID_ASSERT_NEXT(a_integ_in_limits, clock, reset, en1 && (cfg.integ_min <= cfg.integ_max), (front.integ >= $past(cfg.integ_min)) && (front.integ <= $past(cfg.integ_max)), "integrator outside its limits")

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the one-axis attitude PID step block.
`timescale 1ns / 100ps

module testbench;
   import apid_pkg::*;

   // Index 7 decodes to no register; writes there must leave every gain untouched.
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_OF_RANGE = 3'd7;

   localparam int RANDOM_ITEMS   = 900;
   localparam int SEGMENT_ITEMS  = 100;   // new register settings every segment
   localparam int PHASE_ITEMS    = 300;   // idling pattern changes every phase
   localparam int RSP_HOLD_LONG  = 80;    // long back-pressure burst, in cycles
   localparam int DRAIN_CYCLES   = 12;    // lets the pipeline drain, with margin
   localparam int STALL_LIMIT    = 3000;  // cycles with no transaction before giving up

   typedef struct packed {
      logic [2:0]  setting;     // row of phase_settings in force for this row
      logic [15:0] set_point;
      logic [11:0] angle;
      logic [15:0] speed;
      logic        typed;       // 1: compare against want instead of the predictor
      logic [31:0] want;
   } directed_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [15:0]      req_set_point;
   logic signed [11:0]      req_body_angle;
   logic signed [15:0]      req_angle_speed;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [31:0]      rsp_pid_output;
   logic                    csr_write_en;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // Shadow of the control registers and of the loop state, as the block should hold them.
   cfg_type csr_shadow = '0;
   longint  integ_acc    = 0;
   longint  speed_prev   = 0;
   longint  delta_recent = 0;
   longint  delta_prior  = 0;

   logic signed [31:0] pending_outputs [$];
   int error_count     = 0;
   int stall_cycles    = 0;
   int send_idle_pct   = 31;
   int recv_idle_pct   = 72;
   int rsp_hold_cycles = 0;

   // Fixed register sets for the directed rows: reset values, all extremes, integrator
   // pinned high, integrator pinned low, inverted integrator limits, zero error clamp.
   cfg_type phase_settings [6] = '{
      '{15'd0,     16'd0,     16'd0,    16'd0,     32'sd0,          32'sd0,          16'd0},
      '{15'h7FFF,  16'hFFFF,  16'hFFFF, 16'hFFFF,  32'sh8000_0000,  32'sh7FFF_FFFF,  16'hFFFF},
      '{15'h7FFF,  16'hFFFF,  16'hFFFF, 16'hFFFF,  32'sh7FFF_FFFF,  32'sh7FFF_FFFF,  16'hFFFF},
      '{15'h7FFF,  16'hFFFF,  16'hFFFF, 16'hFFFF,  32'sh8000_0000,  32'sh8000_0000,  16'hFFFF},
      '{15'd500,   16'd100,   16'd1520, 16'd4096,  32'sd300,        -32'sd300,       16'd2048},
      '{15'd0,     16'hFFFF,  16'd0,    16'hFFFF,  -32'sd1000,      32'sd1000,       16'd0}
   };

   directed_row_type directed_rows [20] = '{
      // all gains zero after reset: output is zero whatever comes in
      '{3'd0, 16'h0000, 12'h000, 16'h0000, 1'b1, 32'h0000_0000},
      '{3'd0, 16'h7FFF, 12'h7FF, 16'h7FFF, 1'b1, 32'h0000_0000},
      '{3'd0, 16'h8000, 12'h800, 16'h8000, 1'b1, 32'h0000_0000},
      '{3'd0, 16'hFFFF, 12'hFFF, 16'hFFFF, 1'b1, 32'h0000_0000},
      // full-scale gains, field extremes and the largest speed swings
      '{3'd1, 16'h7FFF, 12'h800, 16'h7FFF, 1'b0, 32'h0000_0000},
      '{3'd1, 16'h8000, 12'h7FF, 16'h8000, 1'b0, 32'h0000_0000},
      '{3'd1, 16'h0000, 12'h000, 16'h0000, 1'b0, 32'h0000_0000},
      '{3'd1, 16'h7FFF, 12'h7FF, 16'h7FFF, 1'b0, 32'h0000_0000},
      '{3'd1, 16'h8000, 12'h800, 16'h8000, 1'b0, 32'h0000_0000},
      '{3'd1, 16'h04D2, 12'hEA7, 16'hF448, 1'b0, 32'h0000_0000},
      // integrator pinned at the top: integral term alone overflows 32 bits
      '{3'd2, 16'h0000, 12'h000, 16'h0000, 1'b1, 32'h7FFF_FFFF},
      '{3'd2, 16'h7FFF, 12'h800, 16'h8000, 1'b1, 32'h7FFF_FFFF},
      // integrator pinned at the bottom: saturate negative
      '{3'd3, 16'h8000, 12'h7FF, 16'h7FFF, 1'b1, 32'h8000_0000},
      '{3'd3, 16'h0000, 12'h000, 16'h0000, 1'b1, 32'h8000_0000},
      // lower limit above upper limit: lower test wins, then upper
      '{3'd4, 16'h0064, 12'h000, 16'h0000, 1'b0, 32'h0000_0000},
      '{3'd4, 16'h0000, 12'h000, 16'h0000, 1'b0, 32'h0000_0000},
      '{3'd4, 16'h00C8, 12'h000, 16'h0064, 1'b0, 32'h0000_0000},
      '{3'd4, 16'hFF38, 12'h032, 16'hFF9C, 1'b0, 32'h0000_0000},
      // error clamp of zero: only the integrator's held value can contribute
      '{3'd5, 16'h7FFF, 12'h800, 16'h03E8, 1'b0, 32'h0000_0000},
      '{3'd5, 16'h8000, 12'h7FF, 16'hFC18, 1'b0, 32'h0000_0000}
   };

   attitude_pid_step uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_set_point   (req_set_point),
      .req_body_angle  (req_body_angle),
      .req_angle_speed (req_angle_speed),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pid_output  (rsp_pid_output),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One control step: clamp the error, form P, R, I and D, advance the loop state and
   // saturate the sum. All arithmetic is 64-bit signed; division truncates toward zero.
   function automatic logic signed [31:0] predict_pid_output(input logic signed [15:0] sp,
                                                             input logic signed [11:0] ang,
                                                             input logic signed [15:0] spd);
      longint lsp, lang, lspd, lim, err, lo, hi, prop, integ_term, delta, dsum, deriv, total;
      lsp  = sp;
      lang = ang;
      lspd = spd;
      lim  = longint'(csr_shadow.max_inclination);
      err  = 2 * lsp - lang;
      if (err < -lim)
         err = -lim;
      else if (err > lim)
         err = lim;

      prop = (longint'(csr_shadow.prop_gain) * err) / 100;
      prop = prop - ((lspd * longint'(csr_shadow.rate_gain)) / 80) / 19;

      // lower limit is tested first, which decides the inverted-limit case
      lo = longint'($signed(csr_shadow.integ_min));
      hi = longint'($signed(csr_shadow.integ_max));
      integ_acc = integ_acc + err;
      if (integ_acc < lo)
         integ_acc = lo;
      else if (integ_acc > hi)
         integ_acc = hi;
      integ_term = (integ_acc * longint'(csr_shadow.integ_gain)) / 4096;

      delta        = lspd - speed_prev;
      speed_prev   = lspd;
      dsum         = delta + delta_recent + delta_prior;
      delta_prior  = delta_recent;
      delta_recent = delta;
      deriv        = (dsum * longint'(csr_shadow.deriv_gain)) / 2048;

      total = prop + integ_term - deriv;
      if (total > 64'sd2147483647)
         total = 64'sd2147483647;
      else if (total < -64'sd2147483648)
         total = -64'sd2147483648;
      return total[31:0];
   endfunction

   function automatic logic [15:0] random_gain();
      case ($urandom_range(3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mix extreme and in-range settings; integrator limits come narrow, inverted,
   // full-scale or raw 32-bit so that both clamps and saturation are reached.
   function automatic cfg_type random_settings();
      cfg_type s;
      case ($urandom_range(3))
         0: s.max_inclination = 15'h0000;
         1: s.max_inclination = 15'h7FFF;
         default: s.max_inclination = 15'($urandom_range(1, 3000));
      endcase
      s.prop_gain  = random_gain();
      s.rate_gain  = random_gain();
      s.integ_gain = random_gain();
      s.deriv_gain = random_gain();
      case ($urandom_range(3))
         0: begin
            s.integ_min = 32'(0 - $urandom_range(200000));
            s.integ_max = 32'($urandom_range(200000));
         end
         1: begin
            s.integ_min = 32'($urandom_range(1, 200000));
            s.integ_max = 32'(0 - $urandom_range(1, 200000));
         end
         2: begin
            s.integ_min = 32'sh8000_0000;
            s.integ_max = 32'sh7FFF_FFFF;
         end
         default: begin
            s.integ_min = $urandom;
            s.integ_max = $urandom;
         end
      endcase
      return s;
   endfunction

   // Write one register and mirror it in the shadow; out-of-range indexes change nothing.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_MAX_INCLINATION: csr_shadow.max_inclination = data[14:0];
         REG_PROP_GAIN:       csr_shadow.prop_gain       = data[15:0];
         REG_RATE_GAIN:       csr_shadow.rate_gain       = data[15:0];
         REG_INTEG_GAIN:      csr_shadow.integ_gain      = data[15:0];
         REG_INTEG_MIN:       csr_shadow.integ_min       = data;
         REG_INTEG_MAX:       csr_shadow.integ_max       = data;
         REG_DERIV_GAIN:      csr_shadow.deriv_gain      = data[15:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input cfg_type s);
      write_reg(REG_MAX_INCLINATION, 32'(s.max_inclination));
      write_reg(REG_PROP_GAIN,       32'(s.prop_gain));
      write_reg(REG_RATE_GAIN,       32'(s.rate_gain));
      write_reg(REG_INTEG_GAIN,      32'(s.integ_gain));
      write_reg(REG_INTEG_MIN,       s.integ_min);
      write_reg(REG_INTEG_MAX,       s.integ_max);
      write_reg(REG_DERIV_GAIN,      32'(s.deriv_gain));
      // junk to the unused index: must be dropped by the block
      write_reg(REG_OUT_OF_RANGE,    32'hFFFF_FFFF);
   endtask

   // Drop valid and hold until every predicted output has come back.
   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
   endtask

   // Offer one transaction after a random number of idle cycles; hold the payload
   // until accepted, then predict its output. Typed rows override the prediction
   // but still advance the shadow state.
   task automatic send_item(input logic [15:0] sp, input logic [11:0] ang,
                            input logic [15:0] spd, input logic typed,
                            input logic [31:0] want);
      logic signed [31:0] predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_set_point   <= sp;
      req_body_angle  <= ang;
      req_angle_speed <= spd;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = predict_pid_output(sp, ang, spd);
      pending_outputs.push_back(typed ? $signed(want) : predicted);
   endtask

   // Result side: random back-pressure, or a counted hold-off when one is requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Compare each accepted output with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: pid_output %0d arrived with no transaction outstanding",
                        rsp_pid_output);
         end else if (rsp_pid_output !== pending_outputs[0]) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: pid_output expected %0d (%h) got %0d (%h)",
                        pending_outputs[0], pending_outputs[0], rsp_pid_output,
                        rsp_pid_output);
            void'(pending_outputs.pop_front());
         end else begin
            void'(pending_outputs.pop_front());
         end
      end
   end

   // Watchdog: give up when neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int          n;
      logic [2:0]  active_setting;
      logic [15:0] sp;
      logic [15:0] spd;
      logic [15:0] speed_walk;
      logic [11:0] ang;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_set_point   = '0;
      req_body_angle  = '0;
      req_angle_speed = '0;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      active_setting  = 3'd0;
      speed_walk      = '0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed rows; registers change only with the pipeline empty.
      for (n = 0; n < $size(directed_rows); n++) begin
         if (directed_rows[n].setting != active_setting) begin
            wait_all_results();
            active_setting = directed_rows[n].setting;
            write_settings(phase_settings[active_setting]);
         end
         send_item(directed_rows[n].set_point, directed_rows[n].angle,
                   directed_rows[n].speed, directed_rows[n].typed, directed_rows[n].want);
      end

      // Random part: fresh settings each segment, idling pattern swaps each phase.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_ITEMS == 0) begin
            wait_all_results();
            if (n == PHASE_ITEMS) begin
               send_idle_pct = 72;
               recv_idle_pct = 31;
            end else if (n == 2 * PHASE_ITEMS) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            write_settings(random_settings());
            // stall the result side while the sender streams, so the input backs up
            if (n == 2 * PHASE_ITEMS) begin
               @(posedge clock);
               rsp_hold_cycles = RSP_HOLD_LONG;
            end
         end
         // half full-range values, half small ones so the error clamp is not always hit
         sp  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3000) - 1500);
         ang = 12'($urandom);
         // a slow speed walk gives realistic deltas; raw values give the big swings
         if ($urandom_range(1))
            speed_walk = 16'($urandom);
         else
            speed_walk = 16'(speed_walk + $urandom_range(400) - 200);
         spd = speed_walk;
         send_item(sp, ang, spd, 1'b0, 32'h0000_0000);
      end

      wait_all_results();
      // any late or extra output lands during this window and is flagged
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_outputs.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
